>>> rtl/assert_macros.svh
// Assertion macros for the block pool RTL.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BBPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define BBPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bbpr_pkg.sv
// Package for the block pool allocator: action and status codes,
// default geometry and register map constants. No dependencies.
package bbpr_pkg;

    // Default pool geometry
    localparam int BLOCK_COUNT_DEF = 32;
    localparam int BLOCK_SIZE_DEF  = 64;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int ADDR_EXT_W = ADDR_W + 1;
    localparam int REF_W      = 8;
    localparam int FREE_W     = 6;

    // Register map: one 32-bit register at word 0
    localparam int          APB_ADDR_W        = 3;
    localparam logic [0:0]  REG_BASE_ADDRESS  = 1'b0;

    localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};
    localparam logic [REF_W-1:0] REF_ONE = REF_W'(1);

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_ADDREF = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

endpackage

>>> rtl/bitmap_block_pool_refcount.sv
// Top level of the fixed-block pool allocator with reference counts.
// Depends on bbpr_pkg and assert_macros.svh.
//
//  channel   ports                                  role
//  -------   -------------------------------------  -------------------------
//  s_        s_valid s_ready s_action s_address     request in (alloc/free/ref)
//  m_        m_valid m_ready m_status ...           one result per request
//  apb       psel penable pwrite paddr pwdata ...   base_address register
//
//  One request per cycle sustained while the result is not stalled; an accepted
//  request passes the input register, then the result register. The block match,
//  highest-free pick and count update all sit in the single stage between those registers.
//  Reset marks every block free, clears the counts and loads the block start
//  table for a zero base.
//  A stalled result holds the input stage; a request is still taken while the
//  input stage is empty or moving.
`include "assert_macros.svh"

module bitmap_block_pool_refcount
    import bbpr_pkg::*;
#(
    parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
    parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [ADDR_W-1:0]     s_address,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [ADDR_W-1:0]     m_block_address,
    output logic [FREE_W-1:0]     m_free_blocks,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(BLOCK_COUNT + 1);

    // Control and state
    logic                    in_valid_reg;
    logic                    m_valid_reg;
    logic [BLOCK_COUNT-1:0]  free_map_reg;
    logic [BLOCK_COUNT-1:0]  free_map_next;
    logic [CNT_W-1:0]        free_cnt_reg;
    logic [CNT_W-1:0]        free_cnt_next;
    logic [REF_W-1:0]        ref_cnt_reg  [BLOCK_COUNT];
    logic [REF_W-1:0]        ref_cnt_next [BLOCK_COUNT];
    logic [ADDR_EXT_W-1:0]   blk_addr_reg [BLOCK_COUNT];

    // Input stage payload
    action_t                 action_reg;
    logic [ADDR_W-1:0]       address_reg;

    // Result register
    status_t                 status_reg;
    status_t                 status_next;
    logic [ADDR_W-1:0]       blk_out_reg;
    logic [ADDR_W-1:0]       blk_out_next;
    logic [FREE_W-1:0]       free_out_reg;

    logic                    advance;
    logic                    do_step;
    logic                    s_take;
    logic                    cfg_wr;

    logic [BLOCK_COUNT-1:0]  hit;
    logic [BLOCK_COUNT-1:0]  used_hit;
    logic                    ref_ok;
    logic [BLOCK_COUNT-1:0]  free_rev;
    logic [BLOCK_COUNT-1:0]  low_rev;
    logic [BLOCK_COUNT-1:0]  alloc_oh;
    logic [ADDR_W-1:0]       alloc_addr;
    logic [BLOCK_COUNT-1:0]  alloc_sel;
    logic [BLOCK_COUNT-1:0]  release_sel;

    // Handshake
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;
    assign do_step = in_valid_reg && advance;

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_block_address = blk_out_reg;
    assign m_free_blocks   = free_out_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_BASE_ADDRESS);

    always_comb begin
        if (paddr[APB_ADDR_W-1:2] == REG_BASE_ADDRESS) begin
            prdata = blk_addr_reg[0][ADDR_W-1:0];
        end else begin
            prdata = '0;
        end
    end

    // Match the request address against every block start (no wrap)
    always_comb begin
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            hit[i] = ({1'b0, address_reg} == blk_addr_reg[i]);
        end
    end

    assign used_hit = hit & ~free_map_reg;
    assign ref_ok   = |used_hit;

    // Isolate the highest free block: reverse, keep lowest set bit, reverse back
    always_comb begin
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            free_rev[i] = free_map_reg[BLOCK_COUNT-1-i];
        end
    end

    assign low_rev = free_rev & (~free_rev + BLOCK_COUNT'(1));

    always_comb begin
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            alloc_oh[i] = low_rev[BLOCK_COUNT-1-i];
        end
    end

    // Select the picked block's address
    always_comb begin
        alloc_addr = '0;
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            alloc_addr = alloc_addr | ({ADDR_W{alloc_oh[i]}} & blk_addr_reg[i][ADDR_W-1:0]);
        end
    end

    // Request decode and count update
    always_comb begin
        status_next  = ST_INVALID;
        blk_out_next = '0;
        alloc_sel    = '0;
        release_sel  = '0;
        ref_cnt_next = ref_cnt_reg;
        unique case (action_reg)
            ACT_ALLOC: begin
                if (|free_map_reg) begin
                    status_next  = ST_OK;
                    alloc_sel    = alloc_oh;
                    blk_out_next = alloc_addr;
                end else begin
                    status_next = ST_FULL;
                end
            end
            ACT_FREE: begin
                if (ref_ok) begin
                    status_next = ST_OK;
                end
                for (int i = 0; i < BLOCK_COUNT; i++) begin
                    if (used_hit[i]) begin
                        if (ref_cnt_reg[i] != '0) begin
                            ref_cnt_next[i] = ref_cnt_reg[i] - REF_ONE;
                        end
                        if (ref_cnt_reg[i] <= REF_ONE) begin
                            release_sel[i] = 1'b1;
                        end
                    end
                end
            end
            ACT_ADDREF: begin
                if (ref_ok) begin
                    status_next = ST_OK;
                end
                for (int i = 0; i < BLOCK_COUNT; i++) begin
                    if (used_hit[i] && (ref_cnt_reg[i] != REF_MAX)) begin
                        ref_cnt_next[i] = ref_cnt_reg[i] + REF_ONE;
                    end
                end
            end
            default: begin
                status_next = ST_INVALID;
            end
        endcase
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            if (alloc_sel[i]) begin
                ref_cnt_next[i] = REF_ONE;
            end
        end
    end

    assign free_map_next = (free_map_reg & ~alloc_sel) | release_sel;
    assign free_cnt_next = free_cnt_reg - CNT_W'(|alloc_sel) + CNT_W'(|release_sel);

    // Control registers and pool state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            free_map_reg <= '1;
            free_cnt_reg <= CNT_W'(BLOCK_COUNT);
            for (int i = 0; i < BLOCK_COUNT; i++) begin
                ref_cnt_reg[i]  <= '0;
                blk_addr_reg[i] <= ADDR_EXT_W'(i * BLOCK_SIZE);
            end
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (do_step) begin
                free_map_reg <= free_map_next;
                free_cnt_reg <= free_cnt_next;
                ref_cnt_reg  <= ref_cnt_next;
            end
            // Rebuild the block start table on a base write
            if (cfg_wr) begin
                for (int i = 0; i < BLOCK_COUNT; i++) begin
                    blk_addr_reg[i] <= {1'b0, pwdata} + ADDR_EXT_W'(i * BLOCK_SIZE);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            action_reg  <= action_t'(s_action);
            address_reg <= s_address;
        end
        if (do_step) begin
            status_reg   <= status_next;
            blk_out_reg  <= blk_out_next;
            free_out_reg <= FREE_W'(free_cnt_next);
        end
    end

    // Checks
    `BBPR_ASSERT(a_free_count_tracks_map, free_cnt_reg == $countones(free_map_reg), "free count out of step with free map")
    `BBPR_ASSERT(a_full_means_empty, !m_valid_reg || (status_reg != ST_FULL) || (free_out_reg == '0), "pool full reported with free blocks left")
    `BBPR_ASSERT(a_addr_only_on_ok, !m_valid_reg || (status_reg == ST_OK) || (blk_out_reg == '0), "block address set on a failed transaction")
    `BBPR_ASSERT_NEXT(a_alloc_succeeds, do_step && (action_reg == ACT_ALLOC) && (|free_map_reg), m_valid_reg && (status_reg == ST_OK), "allocation with a free block did not succeed")

endmodule
